// ===== rtl/cio_pkg.sv =====
// Shared types, port codes and constants of the console I/O port block.
`timescale 1ns / 1ps

package cio_pkg;

   // Memory sizes
   localparam int unsigned EXT_EEPROM_BYTES_DEF = 2048;
   localparam int unsigned INT_EEPROM_BYTES     = 1024;
   localparam int unsigned INT_ADDR_W           = $clog2(INT_EEPROM_BYTES);
   localparam int unsigned EXT_ADDR_MAX_W       = 16;
   localparam int unsigned PORT_COUNT           = 256;

   // Queue between the front and the back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration port
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned EXT_MASK_W    = 11;
   localparam logic [EXT_MASK_W-1:0] EXT_MASK_RESET = 11'h7FF;
   localparam logic REG_EXT_MASK = 1'b0;

   // Commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Plain read windows of the port file
   localparam logic [7:0] PLAIN_A_LO = 8'h4E;
   localparam logic [7:0] PLAIN_A_HI = 8'h51;
   localparam logic [7:0] PLAIN_B_LO = 8'h80;
   localparam logic [7:0] PLAIN_B_HI = 8'h94;

   // Port numbers
   localparam logic [7:0] PORT_DMA_SRC_LO = 8'h40;
   localparam logic [7:0] PORT_DMA_SRC_HI = 8'h41;
   localparam logic [7:0] PORT_DMA_DST_LO = 8'h44;
   localparam logic [7:0] PORT_DMA_DST_HI = 8'h45;
   localparam logic [7:0] PORT_DMA_LEN_LO = 8'h46;
   localparam logic [7:0] PORT_DMA_LEN_HI = 8'h47;
   localparam logic [7:0] PORT_DMA_CTRL   = 8'h48;
   localparam logic [7:0] PORT_HW_ID      = 8'hAA;
   localparam logic [7:0] PORT_HW_TYPE    = 8'hB3;
   localparam logic [7:0] PORT_KEYPAD     = 8'hB5;
   localparam logic [7:0] PORT_IEE_DATA_L = 8'hBA;
   localparam logic [7:0] PORT_IEE_DATA_H = 8'hBB;
   localparam logic [7:0] PORT_IEE_ADDR_L = 8'hBC;
   localparam logic [7:0] PORT_IEE_ADDR_H = 8'hBD;
   localparam logic [7:0] PORT_IEE_CMD    = 8'hBE;
   localparam logic [7:0] PORT_SYS_CTRL   = 8'hC0;
   localparam logic [7:0] PORT_BANK_1     = 8'hC2;
   localparam logic [7:0] PORT_BANK_2     = 8'hC3;
   localparam logic [7:0] PORT_EEE_DATA_L = 8'hC4;
   localparam logic [7:0] PORT_EEE_DATA_H = 8'hC5;
   localparam logic [7:0] PORT_EEE_ADDR_L = 8'hC6;
   localparam logic [7:0] PORT_EEE_ADDR_H = 8'hC7;
   localparam logic [7:0] PORT_EEE_CMD    = 8'hC8;
   localparam logic [7:0] PORT_RTC_CMD    = 8'hCA;
   localparam logic [7:0] PORT_RTC_DATA   = 8'hCB;

   // Fixed and derived values
   localparam logic [7:0] HW_ID_VALUE     = 8'hFF;
   localparam logic [7:0] HW_TYPE_MID     = 8'h84;
   localparam logic [7:0] HW_TYPE_HIGH    = 8'hC4;
   localparam logic [7:0] SYS_CTRL_FIXED  = 8'h20;
   localparam logic [7:0] READ_READY_BIT  = 8'h80;
   localparam logic [7:0] RTC_READ_CMD    = 8'h15;
   localparam logic [2:0] RTC_LAST_INDEX  = 3'd6;

   // Where the back takes a read result from, or which EEPROM a write also stores to
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_PORT,
      SRC_INT,
      SRC_EXT
   } src_type;

   // One classified access, handed from the front to the back
   typedef struct packed {
      logic                      is_write;
      src_type                   src;
      logic [7:0]                port_addr;
      logic [INT_ADDR_W-1:0]     int_addr;
      logic [EXT_ADDR_MAX_W-1:0] ext_addr;
      logic [7:0]                wdata;
      logic [7:0]                imm;
      logic                      fwd;
   } work_type;

endpackage

// ===== rtl/cio_front.sv =====
// Front of the console I/O block: accepts words, keeps the control ports and classifies.
`timescale 1ns / 1ps

module cio_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [cio_pkg::EXT_MASK_W-1:0]       ext_eeprom_mask,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [7:0]                           req_port,
   input  logic [7:0]                           req_write_data,
   input  logic [7:0]                           req_keys_pressed,
   input  logic                                 queue_full,
   output logic                                 push_valid,
   output cio_pkg::work_type                    push_data
);
   import cio_pkg::*;

   logic accept;

   // Copies of the ports whose values steer reads, addresses or side effects
   logic [7:0] src_lo_ff, src_hi_ff, dst_lo_ff, dst_hi_ff, len_lo_ff, len_hi_ff;
   logic [7:0] b3_ff, b5_ff, bc_ff, bd_ff, be_ff, c0_ff, c6_ff, c7_ff, c8_ff, ca_ff, cb_ff;
   logic [7:0] src_lo_in, src_hi_in, dst_lo_in, dst_hi_in, len_lo_in, len_hi_in;
   logic [7:0] b3_in, b5_in, bc_in, bd_in, be_in, c0_in, c6_in, c7_in, c8_in, ca_in, cb_in;
   logic [2:0] rtc_idx_ff, rtc_idx_in;

   logic [15:0] dma_src_sum, dma_dst_sum, dma_len;
   logic [15:0] ext_raw;
   logic        plain_hit;
   work_type    work;

   function automatic logic [7:0] ack_status(input logic [7:0] v);
      logic [7:0] r;
      if (v[5]) begin
         r = v | 8'h02;
      end else if (v[4]) begin
         r = v | 8'h01;
      end else begin
         r = v | 8'h03;
      end
      return r;
   endfunction

   assign accept     = req_valid && !queue_full;
   assign req_stall  = queue_full;
   assign push_valid = accept;
   assign push_data  = work;

   assign dma_len     = {len_hi_ff, len_lo_ff};
   assign dma_src_sum = {src_hi_ff, src_lo_ff} + dma_len;
   assign dma_dst_sum = {dst_hi_ff, dst_lo_ff} + dma_len;

   // The two address bytes overlap in bit 8; the odd data port sets bit 0.
   assign ext_raw = {c7_ff, 8'h00} | {7'h00, c6_ff, req_port[0]};

   assign plain_hit = (req_port >= PLAIN_A_LO && req_port <= PLAIN_A_HI) ||
                      (req_port >= PLAIN_B_LO && req_port <= PLAIN_B_HI);

   always_comb begin
      src_lo_in  = src_lo_ff;
      src_hi_in  = src_hi_ff;
      dst_lo_in  = dst_lo_ff;
      dst_hi_in  = dst_hi_ff;
      len_lo_in  = len_lo_ff;
      len_hi_in  = len_hi_ff;
      b3_in      = b3_ff;
      b5_in      = b5_ff;
      bc_in      = bc_ff;
      bd_in      = bd_ff;
      be_in      = be_ff;
      c0_in      = c0_ff;
      c6_in      = c6_ff;
      c7_in      = c7_ff;
      c8_in      = c8_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      rtc_idx_in = rtc_idx_ff;

      work.is_write  = (req_command == CMD_WRITE);
      work.src       = SRC_NONE;
      work.port_addr = req_port;
      work.int_addr  = {bd_ff[0], bc_ff, req_port[0]};
      work.ext_addr  = ext_raw & {{(EXT_ADDR_MAX_W - EXT_MASK_W){1'b0}}, ext_eeprom_mask};
      work.wdata     = req_write_data;
      work.imm       = 8'h00;
      work.fwd       = 1'b0;

      if (req_command == CMD_WRITE) begin
         case (req_port)
            PORT_DMA_SRC_LO: src_lo_in = req_write_data;
            PORT_DMA_SRC_HI: src_hi_in = req_write_data;
            PORT_DMA_DST_LO: dst_lo_in = req_write_data;
            PORT_DMA_DST_HI: dst_hi_in = req_write_data;
            PORT_DMA_LEN_LO: len_lo_in = req_write_data;
            PORT_DMA_LEN_HI: len_hi_in = req_write_data;
            PORT_HW_TYPE:    b3_in     = req_write_data;
            PORT_KEYPAD:     b5_in     = req_write_data;
            PORT_IEE_ADDR_L: bc_in     = req_write_data;
            PORT_IEE_ADDR_H: bd_in     = req_write_data;
            PORT_IEE_CMD:    be_in     = req_write_data;
            PORT_SYS_CTRL:   c0_in     = req_write_data;
            PORT_EEE_ADDR_L: c6_in     = req_write_data;
            PORT_EEE_ADDR_H: c7_in     = req_write_data;
            PORT_EEE_CMD:    c8_in     = req_write_data;
            PORT_RTC_CMD:    ca_in     = req_write_data;
            PORT_RTC_DATA:   cb_in     = req_write_data;
            default: ;
         endcase

         case (req_port)
            PORT_DMA_CTRL: begin
               // A started transfer copies nothing but moves both pointers past it.
               if (req_write_data[7]) begin
                  src_lo_in = dma_src_sum[7:0];
                  src_hi_in = dma_src_sum[15:8];
                  dst_lo_in = dma_dst_sum[7:0];
                  dst_hi_in = dma_dst_sum[15:8];
                  len_lo_in = 8'h00;
                  len_hi_in = 8'h00;
               end
            end
            PORT_IEE_DATA_L, PORT_IEE_DATA_H: work.src = SRC_INT;
            PORT_EEE_DATA_L, PORT_EEE_DATA_H: work.src = SRC_EXT;
            PORT_RTC_CMD: begin
               if (req_write_data == RTC_READ_CMD) begin
                  rtc_idx_in = 3'd0;
               end
            end
            PORT_SYS_CTRL, PORT_BANK_1, PORT_BANK_2: ;
            default: work.fwd = 1'b1;
         endcase
      end else if (plain_hit) begin
         work.src = SRC_PORT;
      end else begin
         case (req_port)
            PORT_HW_ID: work.imm = HW_ID_VALUE;
            PORT_HW_TYPE: begin
               if (!b3_ff[7]) begin
                  work.imm = 8'h00;
               end else if (!b3_ff[6]) begin
                  work.imm = HW_TYPE_MID;
               end else begin
                  work.imm = HW_TYPE_HIGH;
               end
            end
            PORT_KEYPAD: begin
               if (b5_ff[6]) begin
                  work.imm = {b5_ff[7:4], req_keys_pressed[1], req_keys_pressed[0],
                              req_keys_pressed[3], 1'b0};
               end else if (b5_ff[5]) begin
                  work.imm = {b5_ff[7:4], req_keys_pressed[5], req_keys_pressed[7],
                              req_keys_pressed[4], req_keys_pressed[6]};
               end else begin
                  work.imm = {b5_ff[7:4], 4'h0};
               end
            end
            PORT_IEE_CMD:    work.imm = ack_status(be_ff);
            PORT_IEE_DATA_L, PORT_IEE_DATA_H: work.src = SRC_INT;
            PORT_SYS_CTRL:   work.imm = {4'h0, c0_ff[3:0]} | SYS_CTRL_FIXED;
            PORT_EEE_DATA_L, PORT_EEE_DATA_H: work.src = SRC_EXT;
            PORT_EEE_CMD:    work.imm = ack_status(c8_ff);
            PORT_RTC_CMD:    work.imm = ca_ff | READ_READY_BIT;
            PORT_RTC_DATA: begin
               // While the read command is set, each data read steps the sequence.
               if (ca_ff == RTC_READ_CMD) begin
                  work.imm   = 8'h00;
                  rtc_idx_in = (rtc_idx_ff >= RTC_LAST_INDEX) ? 3'd0 : rtc_idx_ff + 3'd1;
               end else begin
                  work.imm = cb_ff | READ_READY_BIT;
               end
            end
            default: work.fwd = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_lo_ff  <= 8'h00;
         src_hi_ff  <= 8'h00;
         dst_lo_ff  <= 8'h00;
         dst_hi_ff  <= 8'h00;
         len_lo_ff  <= 8'h00;
         len_hi_ff  <= 8'h00;
         b3_ff      <= 8'h00;
         b5_ff      <= 8'h00;
         bc_ff      <= 8'h00;
         bd_ff      <= 8'h00;
         be_ff      <= 8'h00;
         c0_ff      <= 8'h00;
         c6_ff      <= 8'h00;
         c7_ff      <= 8'h00;
         c8_ff      <= 8'h00;
         ca_ff      <= 8'h00;
         cb_ff      <= 8'h00;
         rtc_idx_ff <= 3'd0;
      end else if (accept) begin
         src_lo_ff  <= src_lo_in;
         src_hi_ff  <= src_hi_in;
         dst_lo_ff  <= dst_lo_in;
         dst_hi_ff  <= dst_hi_in;
         len_lo_ff  <= len_lo_in;
         len_hi_ff  <= len_hi_in;
         b3_ff      <= b3_in;
         b5_ff      <= b5_in;
         bc_ff      <= bc_in;
         bd_ff      <= bd_in;
         be_ff      <= be_in;
         c0_ff      <= c0_in;
         c6_ff      <= c6_in;
         c7_ff      <= c7_in;
         c8_ff      <= c8_in;
         ca_ff      <= ca_in;
         cb_ff      <= cb_in;
         rtc_idx_ff <= rtc_idx_in;
      end
   end

endmodule

// ===== rtl/cio_queue.sv =====
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps

module cio_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cio_pkg::work_type push_data,
   output logic              full,
   input  logic              pop_ready,
   output logic              pop_valid,
   output cio_pkg::work_type pop_data
);
   import cio_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/cio_back.sv =====
// Back of the console I/O block: port file and EEPROM memories, result register.
`timescale 1ns / 1ps

module cio_back #(
   parameter int unsigned EXT_EEPROM_BYTES = cio_pkg::EXT_EEPROM_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  cio_pkg::work_type pop_data,
   output logic              pop_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_forward_to_video
);
   import cio_pkg::*;

   localparam int unsigned EXT_AW = $clog2(EXT_EEPROM_BYTES);

   logic [7:0] port_mem [PORT_COUNT];
   logic [7:0] int_mem  [INT_EEPROM_BYTES];
   logic [7:0] ext_mem  [EXT_EEPROM_BYTES];

   // The port file resets to zero: one written flag per port.
   logic [PORT_COUNT-1:0] port_ok_ff;
   // EEPROM bytes 0 and 1 are zero after reset until written again.
   logic [1:0]            int_low_ok_ff;
   logic [1:0]            ext_low_ok_ff;

   logic [7:0]  port_q_ff, int_q_ff, ext_q_ff;
   logic        rd_valid_ff;
   src_type     rd_src_ff;
   logic        rd_zero_ff;
   logic [7:0]  rd_imm_ff;
   logic        rd_fwd_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_fwd_ff;

   logic              pop, advance;
   logic [EXT_AW-1:0] ext_a;
   logic              int_low, ext_low;
   logic              int_we, ext_we;
   logic              zero_in;
   logic [7:0]        data_in;

   assign advance   = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop_ready = !rd_valid_ff || advance;
   assign pop       = pop_valid && pop_ready;

   assign ext_a   = pop_data.ext_addr[EXT_AW-1:0];
   assign int_low = (pop_data.int_addr[INT_ADDR_W-1:1] == '0);
   assign ext_low = (ext_a[EXT_AW-1:1] == '0);
   assign int_we  = pop && pop_data.is_write && (pop_data.src == SRC_INT);
   assign ext_we  = pop && pop_data.is_write && (pop_data.src == SRC_EXT);

   always_comb begin
      case (pop_data.src)
         SRC_PORT: zero_in = !port_ok_ff[pop_data.port_addr];
         SRC_INT:  zero_in = int_low && !int_low_ok_ff[pop_data.int_addr[0]];
         SRC_EXT:  zero_in = ext_low && !ext_low_ok_ff[ext_a[0]];
         default:  zero_in = 1'b0;
      endcase
   end

   always_comb begin
      case (rd_src_ff)
         SRC_PORT: data_in = port_q_ff;
         SRC_INT:  data_in = int_q_ff;
         SRC_EXT:  data_in = ext_q_ff;
         default:  data_in = rd_imm_ff;
      endcase
      if (rd_zero_ff) begin
         data_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (pop_data.is_write) begin
            port_mem[pop_data.port_addr] <= pop_data.wdata;
         end
         port_q_ff <= port_mem[pop_data.port_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (int_we) begin
         int_mem[pop_data.int_addr] <= pop_data.wdata;
      end
      if (pop) begin
         int_q_ff <= int_mem[pop_data.int_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_mem[ext_a] <= pop_data.wdata;
      end
      if (pop) begin
         ext_q_ff <= ext_mem[ext_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ok_ff    <= '0;
         int_low_ok_ff <= 2'b00;
         ext_low_ok_ff <= 2'b00;
      end else begin
         if (pop && pop_data.is_write) begin
            port_ok_ff[pop_data.port_addr] <= 1'b1;
         end
         if (int_we && int_low) begin
            int_low_ok_ff[pop_data.int_addr[0]] <= 1'b1;
         end
         if (ext_we && ext_low) begin
            ext_low_ok_ff[ext_a[0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rd_valid_ff <= pop_valid;
      end
   end

   // A write returns its immediate zero, so its memory source is dropped here.
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_src_ff  <= pop_data.is_write ? SRC_NONE : pop_data.src;
         rd_zero_ff <= !pop_data.is_write && zero_in;
         rd_imm_ff  <= pop_data.imm;
         rd_fwd_ff  <= pop_data.fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= data_in;
         rsp_fwd_ff  <= rd_fwd_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_data_ff;
   assign rsp_forward_to_video = rsp_fwd_ff;

endmodule

// ===== rtl/console_io_port_file.sv =====
// Console I/O port block. Each request word is one byte-wide port read or write; each
// produces exactly one response word with the byte read (zero on writes and forwarded
// accesses) and a flag that marks accesses the video block must handle. A new word is
// accepted every cycle while the two-entry queue between the front and the back has
// room; a word passes through a queue slot, the back's read registers and its response
// register, and the sustained rate is one word per cycle while rsp_stall is low, set by
// the single access per cycle that the back makes to its port-file and EEPROM memories.
// The external EEPROM mask lives at byte address 0 of the register port. Reset clears
// the port file, the clock sequence and EEPROM bytes 0 and 1 at once; there is no
// clearing pass. EXT_EEPROM_BYTES must be a power of two between 128 and 65536.
`timescale 1ns / 1ps

module console_io_port_file #(
   parameter int unsigned EXT_EEPROM_BYTES = cio_pkg::EXT_EEPROM_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [7:0]                        req_port,
   input  logic [7:0]                        req_write_data,
   input  logic [7:0]                        req_keys_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_forward_to_video,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cio_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cio_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cio_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import cio_pkg::*;

   logic [EXT_MASK_W-1:0] ext_mask_ff;
   logic                  csr_write;
   logic                  csr_hit;

   logic     push_valid, q_full, pop_valid, pop_ready;
   work_type push_data, pop_data;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == REG_EXT_MASK);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? {{(CSR_DATA_W - EXT_MASK_W){1'b0}}, ext_mask_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_mask_ff <= EXT_MASK_RESET;
      end else if (csr_write && csr_hit) begin
         ext_mask_ff <= pwdata[EXT_MASK_W-1:0];
      end
   end

   cio_front u_front (
      .clock            (clock),
      .reset            (reset),
      .ext_eeprom_mask  (ext_mask_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_port         (req_port),
      .req_write_data   (req_write_data),
      .req_keys_pressed (req_keys_pressed),
      .queue_full       (q_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   cio_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   cio_back #(
      .EXT_EEPROM_BYTES (EXT_EEPROM_BYTES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_data             (pop_data),
      .pop_ready            (pop_ready),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_read_data        (rsp_read_data),
      .rsp_forward_to_video (rsp_forward_to_video)
   );

`ifndef SYNTHESIS
   // The front never pushes a word into a full queue.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("word pushed into a full queue");

   // A forwarded access never carries read data.
   a_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forward_to_video) |-> (rsp_read_data == 8'h00))
      else $error("forwarded access with nonzero read data");

   // A mask write reads back on the next cycle.
   a_mask_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2] == REG_EXT_MASK) |=>
         (ext_mask_ff == $past(pwdata[EXT_MASK_W-1:0])))
      else $error("mask register write lost");
`endif

endmodule
